@@ sv/sample_mode_finder_macros.svh @@
// ----------------------------------------------------------------------------
// Sample mode finder assertion macros
// Concurrent assertion helpers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_MODE_FINDER_MACROS_SVH
`define SAMPLE_MODE_FINDER_MACROS_SVH
`ifndef SYNTHESIS
`define SMF_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sample mode finder assertion failed");
`define SMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sample mode finder assertion failed");
`else
`define SMF_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define SMF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ sv/smf_pkg.sv @@
// ----------------------------------------------------------------------------
// Sample mode finder package
// Shared widths, defaults and the queue entry type.
// ----------------------------------------------------------------------------
`default_nettype none

package smf_pkg;

   localparam int unsigned MAX_SAMPLES_DEFAULT = 256;
   localparam int unsigned SAMPLE_W            = 64;
   localparam int unsigned MODE_COUNT_W        = 9;
   localparam int unsigned QUEUE_DEPTH         = 4;

   // One classified sample on its way from the front to the back.
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last_sample;
      logic                drop;
   } smf_entry_type;

endpackage

`default_nettype wire

@@ sv/smf_req_if.sv @@
// ----------------------------------------------------------------------------
// Sample request channel
// Valid/ready channel carrying one sample and its end-of-set flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface smf_req_if;
   logic                         valid;
   logic                         ready;
   logic [smf_pkg::SAMPLE_W-1:0] sample;
   logic                         last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

`default_nettype wire

@@ sv/smf_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Mode result channel
// Valid/ready channel carrying the mode value, its count and the truncation flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface smf_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [smf_pkg::SAMPLE_W-1:0]     mode_value;
   logic [smf_pkg::MODE_COUNT_W-1:0] mode_count;
   logic                             set_truncated;

   modport source (output valid, output mode_value, output mode_count,
                   output set_truncated, input ready);
   modport sink   (input valid, input mode_value, input mode_count,
                   input set_truncated, output ready);
endinterface

`default_nettype wire

@@ sv/sample_mode_finder.sv @@
// ----------------------------------------------------------------------------
// Sample mode finder
// Collects a set of 64-bit samples and reports the most frequent value.
// ----------------------------------------------------------------------------
// Samples arrive on req_ch, one per transfer; last_sample marks the final
// sample of a set. Up to MAX_SAMPLES samples are stored; later ones in the
// same set are dropped and the result then reports set_truncated.
// Each set yields one transfer on rsp_ch with the mode value (smallest value
// on ties), its count and the truncation flag.
// Samples load at one per cycle while the back end is in its load state and
// the queue holds entries. After the last sample of a set, the search
// compares every candidate against the whole store through the single read
// port of the sample memory; the result then goes to the output register.
// A four-entry queue between the front end and the back end keeps req_ch
// accepting while the back end is searching or waits on a stalled rsp_ch,
// until the queue fills. A waiting result is held in the output register;
// the back end finishes its next search and then waits for that register.
// Reset empties the queue, the fill counts and the output register; the
// store itself needs no clearing, as only entries of the current set are read.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_mode_finder #(
   parameter int unsigned MAX_SAMPLES = smf_pkg::MAX_SAMPLES_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   smf_req_if.sink   req_ch,
   smf_rsp_if.source rsp_ch
);

   // Front to queue.
   logic                   push_valid;
   logic                   push_ready;
   smf_pkg::smf_entry_type push_data;

   // Queue to back.
   logic                   pop_valid;
   logic                   pop_ready;
   smf_pkg::smf_entry_type pop_data;

   // The front end classifies each sample as stored or dropped so that the
   // back end only has to execute the decision.
   smf_front #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data)
   );

   smf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data)
   );

   // The back end owns the sample memory, the search sequencer and the
   // output register.
   smf_back #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_data (pop_data),
      .rsp_ch   (rsp_ch)
   );

endmodule

`default_nettype wire

@@ sv/smf_queue.sv @@
// ----------------------------------------------------------------------------
// Sample mode finder queue
// Small FIFO of classified samples between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sample_mode_finder_macros.svh"

module smf_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push_valid,
   output logic                        push_ready,
   input  wire smf_pkg::smf_entry_type push_data,
   output logic                        pop_valid,
   input  wire logic                   pop_ready,
   output smf_pkg::smf_entry_type      pop_data
);

   localparam int unsigned DEPTH = smf_pkg::QUEUE_DEPTH;
   localparam int unsigned PW    = $clog2(DEPTH);
   localparam int unsigned NW    = $clog2(DEPTH + 1);

   smf_pkg::smf_entry_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic          push, pop;

   assign push_ready = (count_ff != NW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `SMF_ASSERT_NEXT(a_fill_tracks_push, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

`default_nettype wire

@@ sv/smf_front.sv @@
// ----------------------------------------------------------------------------
// Sample mode finder front end
// Accepts samples and marks those that arrive while the store is full.
// ----------------------------------------------------------------------------
`default_nettype none

module smf_front #(
   parameter int unsigned MAX_SAMPLES = smf_pkg::MAX_SAMPLES_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   smf_req_if.sink                 req_ch,
   output logic                    push_valid,
   input  wire logic               push_ready,
   output smf_pkg::smf_entry_type  push_data
);

   localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);

   // Mirrors the fill level that the back end will reach once it has
   // drained everything pushed so far.
   logic [CW-1:0] fill_ff, fill_in;
   logic          full;
   logic          accept;

   assign full       = (fill_ff == CW'(MAX_SAMPLES));
   assign accept     = req_ch.valid && push_ready;
   assign req_ch.ready = push_ready;
   assign push_valid = req_ch.valid;

   always_comb begin
      push_data.sample      = req_ch.sample;
      push_data.last_sample = req_ch.last_sample;
      push_data.drop        = full;
   end

   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         if (req_ch.last_sample) begin
            fill_in = '0;
         end else if (!full) begin
            fill_in = fill_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/smf_back.sv @@
// ----------------------------------------------------------------------------
// Sample mode finder back end
// Writes samples into the store, runs the mode search and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sample_mode_finder_macros.svh"

module smf_back #(
   parameter int unsigned MAX_SAMPLES = smf_pkg::MAX_SAMPLES_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   pop_valid,
   output logic                        pop_ready,
   input  wire smf_pkg::smf_entry_type pop_data,
   smf_rsp_if.source                   rsp_ch
);

   localparam int unsigned AW = $clog2(MAX_SAMPLES);
   localparam int unsigned CW = $clog2(MAX_SAMPLES + 1);
   localparam int unsigned SW = smf_pkg::SAMPLE_W;
   localparam int unsigned MW = smf_pkg::MODE_COUNT_W;

   localparam logic [2:0] S_LOAD   = 3'd0;
   localparam logic [2:0] S_CAND   = 3'd1;
   localparam logic [2:0] S_CLATCH = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_UPD    = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [SW-1:0] store_mem [MAX_SAMPLES];
   logic [SW-1:0] rd_data_ff;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] c_ff, c_in;
   logic [SW-1:0] cand_ff, cand_in;
   logic [SW-1:0] best_value_ff, best_value_in;
   logic [CW-1:0] best_count_ff, best_count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] mode_value_ff, mode_value_in;
   logic [MW-1:0] mode_count_ff, mode_count_in;
   logic          trunc_ff, trunc_in;
   logic [CW+MW-1:0] count_wide;
   logic          better;

   assign pop_ready            = (state_ff == S_LOAD);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.mode_value    = mode_value_ff;
   assign rsp_ch.mode_count    = mode_count_ff;
   assign rsp_ch.set_truncated = trunc_ff;

   // The reported count keeps its low bits only.
   assign count_wide = {{MW{1'b0}}, best_count_ff};
   assign better = (c_ff > best_count_ff) ||
                   ((c_ff == best_count_ff) && (cand_ff < best_value_ff));

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      ovf_in        = ovf_ff;
      n_in          = n_ff;
      i_in          = i_ff;
      k_in          = k_ff;
      c_in          = c_ff;
      cand_in       = cand_ff;
      best_value_in = best_value_ff;
      best_count_in = best_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      mode_value_in = mode_value_ff;
      mode_count_in = mode_count_ff;
      trunc_in      = trunc_ff;
      wr_en         = 1'b0;
      wr_addr       = cnt_ff[AW-1:0];
      rd_addr       = '0;

      case (state_ff)
         S_LOAD: begin
            if (pop_valid) begin
               ovf_in = ovf_ff | pop_data.drop;
               if (!pop_data.drop) begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_ff + CW'(1);
               end
               if (pop_data.last_sample) begin
                  n_in          = pop_data.drop ? cnt_ff : cnt_ff + CW'(1);
                  i_in          = '0;
                  best_value_in = '0;
                  best_count_in = '0;
                  state_in      = S_CAND;
               end
            end
         end
         S_CAND: begin
            rd_addr  = i_ff[AW-1:0];
            state_in = S_CLATCH;
         end
         S_CLATCH: begin
            cand_in  = rd_data_ff;
            rd_addr  = '0;
            k_in     = CW'(1);
            c_in     = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            // The read data belongs to the address issued in the previous cycle.
            c_in = c_ff + CW'(rd_data_ff == cand_ff);
            if (k_ff == n_ff) begin
               state_in = S_UPD;
            end else begin
               rd_addr = k_ff[AW-1:0];
               k_in    = k_ff + CW'(1);
            end
         end
         S_UPD: begin
            if (better) begin
               best_count_in = c_ff;
               best_value_in = cand_ff;
            end
            i_in     = i_ff + CW'(1);
            state_in = (i_ff + CW'(1) == n_ff) ? S_DONE : S_CAND;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               mode_value_in = best_value_ff;
               mode_count_in = count_wide[MW-1:0];
               trunc_in      = ovf_ff;
               cnt_in        = '0;
               ovf_in        = 1'b0;
               state_in      = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      i_ff          <= i_in;
      k_ff          <= k_in;
      c_ff          <= c_in;
      cand_ff       <= cand_in;
      best_value_ff <= best_value_in;
      best_count_ff <= best_count_in;
      mode_value_ff <= mode_value_in;
      mode_count_ff <= mode_count_in;
      trunc_ff      <= trunc_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= pop_data.sample;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   `SMF_ASSERT_IMPLIES(a_scan_bound, clock, reset, state_ff == S_SCAN, (k_ff != '0) && (k_ff <= n_ff))
   `SMF_ASSERT_IMPLIES(a_set_size, clock, reset, state_ff != S_LOAD, (n_ff != '0) && (n_ff <= CW'(MAX_SAMPLES)))
   `SMF_ASSERT_IMPLIES(a_done_count, clock, reset, state_ff == S_DONE, best_count_ff != '0)

endmodule

`default_nettype wire
